// File: rtl/top_k_xor_select_core_macros.svh
// Assertion macros shared by the checkers of the top-k XOR select core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef TOP_K_XOR_SELECT_CORE_MACROS_SVH
`define TOP_K_XOR_SELECT_CORE_MACROS_SVH

`define TKX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`define TKX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/tkx_pkg.sv
// Types and constants for the top-k XOR select core.
// No dependencies; imported by every module of the block.
package tkx_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 7;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} tkx_in_t;

	typedef struct packed {
		logic [VALUE_W-1:0] xor_of_largest;
		logic               short_input;
	} tkx_out_t;

	typedef struct packed {
		logic ins;
		logic drain;
	} tkx_ctl_t;

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_DRAIN = 2'b10
	} tkx_state_t;

endpackage

// File: rtl/tkx_cell.sv
// One cell of the sorted insertion chain: holds one kept value and its valid bit.
// Depends on tkx_pkg.
module tkx_cell
	import tkx_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  tkx_ctl_t                  ctl,
	input  logic                      enable,
	input  logic signed [VALUE_W-1:0] din,
	input  logic signed [VALUE_W-1:0] up_value,
	input  logic                      up_valid,
	input  logic                      up_gt,
	input  logic signed [VALUE_W-1:0] dn_value,
	input  logic                      dn_valid,
	output logic signed [VALUE_W-1:0] value,
	output logic                      valid,
	output logic                      gt
);

	logic signed [VALUE_W-1:0] value_q;
	logic                      valid_q;

	assign value = value_q;
	assign valid = valid_q & enable;
	assign gt    = !valid || (din > value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins) begin
			if (!enable) begin
				valid_q <= 1'b0;
			end else if (gt) begin
				valid_q <= up_gt ? up_valid : 1'b1;
			end else begin
				valid_q <= valid;
			end
		end else if (ctl.drain) begin
			valid_q <= dn_valid & enable;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && enable && gt) begin
			value_q <= up_gt ? up_value : din;
		end else if (ctl.drain) begin
			value_q <= dn_value;
		end
	end

endmodule

// File: rtl/top_k_xor_select_core.sv
// Top level of the top-k XOR select core: control, count register and the cell chain.
// Depends on tkx_pkg and tkx_cell.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   tkx_in_t  (value, last)
//   result    out        result_valid / result_stall  tkx_out_t (xor_of_largest, short_input)
//   cfg       in         cfg_we                    cfg_wdata (top_count)
//
// A beat without last is taken every cycle while item_stall is low; each cell compares it with its own value.
// After a last beat the chain shifts toward cell zero, one kept value per cycle, into
// the XOR accumulator, while item_stall is held high by the drain state.
// The drain leaves every cell empty, so the next run starts clean.
// Reset empties the chain and sets top_count to 1; a stalled result holds in its register.
module top_k_xor_select_core
	import tkx_pkg::*;
#(
	parameter int unsigned MAX_TOP = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  tkx_in_t            item,
	output logic               result_valid,
	input  logic               result_stall,
	output tkx_out_t           result,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	localparam int unsigned LW = $clog2(MAX_TOP + 1);
	localparam int unsigned CW = (LW > COUNT_W) ? LW : COUNT_W;

	tkx_state_t         state_q;
	logic [COUNT_W-1:0] top_count_q;
	logic [CW-1:0]      limit;
	logic [CW-1:0]      held_q;
	logic [VALUE_W-1:0] acc_q;
	logic               result_valid_q;
	tkx_out_t           result_q;
	tkx_ctl_t           ctl;
	logic               accept;

	logic signed [VALUE_W-1:0] cell_value [MAX_TOP];
	logic                      cell_valid [MAX_TOP];
	logic                      cell_gt    [MAX_TOP];

	assign limit = (CW'(top_count_q) > CW'(MAX_TOP)) ? CW'(MAX_TOP) : CW'(top_count_q);

	assign item_stall   = (state_q != ST_RUN);
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign ctl.ins   = accept;
	assign ctl.drain = (state_q == ST_DRAIN) && cell_valid[0];

	for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
		logic signed [VALUE_W-1:0] up_value;
		logic                      up_valid;
		logic                      up_gt;
		logic signed [VALUE_W-1:0] dn_value;
		logic                      dn_valid;

		if (i == 0) begin : g_head
			assign up_value = item.value;
			assign up_valid = 1'b1;
			assign up_gt    = 1'b0;
		end else begin : g_body
			assign up_value = cell_value[i-1];
			assign up_valid = cell_valid[i-1];
			assign up_gt    = cell_gt[i-1];
		end

		if (i == MAX_TOP - 1) begin : g_tail
			assign dn_value = item.value;
			assign dn_valid = 1'b0;
		end else begin : g_mid
			assign dn_value = cell_value[i+1];
			assign dn_valid = cell_valid[i+1];
		end

		tkx_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.enable   (CW'(i) < limit),
			.din      (item.value),
			.up_value (up_value),
			.up_valid (up_valid),
			.up_gt    (up_gt),
			.dn_value (dn_value),
			.dn_valid (dn_valid),
			.value    (cell_value[i]),
			.valid    (cell_valid[i]),
			.gt       (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= COUNT_W'(1);
		end else if (cfg_we) begin
			top_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_RUN;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (accept && item.last) begin
						state_q <= ST_DRAIN;
					end
					if (result_valid_q && !result_stall) begin
						result_valid_q <= 1'b0;
					end
				end
				ST_DRAIN: begin
					if (!cell_valid[0] && (!result_valid_q || !result_stall)) begin
						state_q        <= ST_RUN;
						result_valid_q <= 1'b1;
					end else if (result_valid_q && !result_stall) begin
						result_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.last) begin
			acc_q  <= '0;
			held_q <= '0;
		end else if (ctl.drain) begin
			acc_q  <= acc_q ^ cell_value[0];
			held_q <= held_q + CW'(1);
		end
		if ((state_q == ST_DRAIN) && !cell_valid[0] && (!result_valid_q || !result_stall)) begin
			result_q.xor_of_largest <= acc_q;
			result_q.short_input    <= (held_q < limit);
		end
	end

endmodule

// File: rtl/tkx_checker.sv
// Port-level checker for the top-k XOR select core, bound to the top level.
// Depends on tkx_pkg and top_k_xor_select_core_macros.svh.
`include "top_k_xor_select_core_macros.svh"

module tkx_checker
	import tkx_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input tkx_in_t            item,
	input logic               result_valid,
	input logic               result_stall,
	input tkx_out_t           result
);

	logic item_take;
	logic result_wait;

	assign item_take   = item_valid && !item_stall;
	assign result_wait = result_valid && result_stall;

	`TKX_ASSERT_NEXT(a_last_stalls, item_take && item.last, item_stall, "no drain after last beat")
	`TKX_ASSERT_NOW(a_result_src, $rose(result_valid), $past(item_stall), "result without drain")
	`TKX_ASSERT_NEXT(a_result_holds, result_wait, result_valid, "stalled result was dropped")
	`TKX_ASSERT_NEXT(a_payload_holds, result_wait, $stable(result), "stalled result changed")
	`TKX_ASSERT_NEXT(a_item_holds, item_valid && item_stall, $stable(item), "stalled item changed")

endmodule

bind top_k_xor_select_core tkx_checker u_tkx_checker (.*);
